/* rtl/core/mxh_pkg.sv */
// Package for the multiply-xor string hash block.
// Holds shared widths, command and register codes, structs and the rotate helper.
// Depends on nothing.
package mxh_pkg;

  localparam int WORD_W   = 64;
  localparam int HALF_W   = 32;
  localparam int PROD_W   = 128;
  localparam int ROT_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 5;

  localparam logic       CMD_BYTE   = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;

  localparam logic [1:0] REG_ROTATE = 2'd0;
  localparam logic [1:0] REG_ADDEND = 2'd1;
  localparam logic [1:0] REG_BASIS  = 2'd2;
  localparam logic [1:0] REG_SEED   = 2'd3;

  localparam logic [ROT_W-1:0] ROTATE_RESET = 6'd1;

  typedef struct packed {
    logic [ROT_W-1:0]  rotate_amount;
    logic [WORD_W-1:0] mix_addend;
    logic [WORD_W-1:0] mix_basis;
    logic [WORD_W-1:0] hash_seed;
  } mxh_cfg_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mxh_mix_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] result;
  } mxh_mix_rsp_t;

  // Right rotate; a distance of zero leaves the word unchanged.
  function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v,
                                                  input logic [ROT_W-1:0] r);
    logic [2*WORD_W-1:0] dbl;
    dbl = {v, v} >> r;
    return dbl[WORD_W-1:0];
  endfunction

endpackage

/* rtl/core/mxh_if.sv */
// Stream interfaces for the hash block: command words in, hash words out.
// Depends on mxh_pkg for the field widths.
interface mxh_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [mxh_pkg::BYTE_W-1:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink (input valid, input command, input byte_value, output ready);
endinterface

interface mxh_hash_if;
  logic                       valid;
  logic                       ready;
  logic [mxh_pkg::WORD_W-1:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

/* rtl/core/mxh_cfg_regs.sv */
// APB-style configuration registers of the hash block.
// Depends on mxh_pkg for register codes and the configuration struct.
module mxh_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mxh_pkg::ADDR_W-1:0]         paddr,
  input  logic [mxh_pkg::WORD_W-1:0]         pwdata,
  output logic [mxh_pkg::WORD_W-1:0]         prdata,
  output logic                               pready,
  output mxh_pkg::mxh_cfg_t                  cfg
);

  localparam int ADDR_HI = mxh_pkg::ADDR_W - 1;

  mxh_pkg::mxh_cfg_t cfg_r;
  mxh_pkg::mxh_cfg_t cfg_nxt;
  logic [1:0]        reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_HI:3];
  assign wr_en   = psel & penable & pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        mxh_pkg::REG_ROTATE: cfg_nxt.rotate_amount = pwdata[mxh_pkg::ROT_W-1:0];
        mxh_pkg::REG_ADDEND: cfg_nxt.mix_addend    = pwdata;
        mxh_pkg::REG_BASIS:  cfg_nxt.mix_basis     = pwdata;
        mxh_pkg::REG_SEED:   cfg_nxt.hash_seed     = pwdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mxh_pkg::REG_ROTATE: prdata = {{(mxh_pkg::WORD_W-mxh_pkg::ROT_W){1'b0}},
                                     cfg_r.rotate_amount};
      mxh_pkg::REG_ADDEND: prdata = cfg_r.mix_addend;
      mxh_pkg::REG_BASIS:  prdata = cfg_r.mix_basis;
      mxh_pkg::REG_SEED:   prdata = cfg_r.hash_seed;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotate_amount <= mxh_pkg::ROTATE_RESET;
      cfg_r.mix_addend    <= '0;
      cfg_r.mix_basis     <= '0;
      cfg_r.hash_seed     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/mxh_mix_unit.sv */
// Shared mix unit: pre-rotate step, then a 64x64 product built from four
// 32x32 partial products over successive cycles, then the final fold.
// Depends on mxh_pkg for widths, structs and the rotate helper.
module mxh_mix_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mxh_pkg::mxh_cfg_t     cfg,
  input  mxh_pkg::mxh_mix_req_t req,
  output mxh_pkg::mxh_mix_rsp_t rsp
);

  localparam int W = mxh_pkg::WORD_W;
  localparam int H = mxh_pkg::HALF_W;
  localparam logic [2:0] STEP_PRE  = 3'd0;
  localparam logic [2:0] STEP_LAST = 3'd6;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [2:0]                 step_r, step_nxt;
  logic [W-1:0]               a_r, a_nxt;
  logic [W-1:0]               b_r, b_nxt;
  logic [mxh_pkg::PROD_W-1:0] acc_r, acc_nxt;
  logic [W-1:0]               pp_r, pp_nxt;
  logic [1:0]                 pp_idx_r, pp_idx_nxt;
  logic [W-1:0]               result_r, result_nxt;

  logic [1:0]                 mul_idx;
  logic [H-1:0]               op_x, op_y;
  logic [6:0]                 pp_shift;
  logic [mxh_pkg::PROD_W-1:0] pp_ext;

  assign mul_idx = step_r[1:0] - 2'd1;
  assign op_x    = mul_idx[1] ? a_r[W-1:H] : a_r[H-1:0];
  assign op_y    = mul_idx[0] ? b_r[W-1:H] : b_r[H-1:0];

  always_comb begin
    case (pp_idx_r)
      2'd0:    pp_shift = 7'd0;
      2'd3:    pp_shift = 7'd64;
      default: pp_shift = 7'd32;
    endcase
  end

  assign pp_ext = {{W{1'b0}}, pp_r} << pp_shift;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    acc_nxt    = acc_r;
    pp_nxt     = pp_r;
    pp_idx_nxt = pp_idx_r;
    result_nxt = result_r;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        step_nxt = STEP_PRE;
        a_nxt    = req.a;
        b_nxt    = req.b;
        acc_nxt  = '0;
      end
    end else begin
      step_nxt = step_r + 3'd1;
      if (step_r == STEP_PRE) begin
        a_nxt = a_r ^ mxh_pkg::rot_right(a_r + b_r, cfg.rotate_amount);
      end else if (step_r == STEP_LAST) begin
        result_nxt = (b_r + acc_r[mxh_pkg::PROD_W-1:W] + cfg.mix_addend) ^ acc_r[W-1:0];
        done_nxt   = 1'b1;
        busy_nxt   = 1'b0;
      end else begin
        // Steps one to four issue a partial product; steps two to five add
        // the one registered in the cycle before.
        if (step_r <= 3'd4) begin
          pp_nxt     = op_x * op_y;
          pp_idx_nxt = mul_idx;
        end
        if (step_r >= 3'd2) begin
          acc_nxt = acc_r + pp_ext;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= STEP_PRE;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    acc_r    <= acc_nxt;
    pp_r     <= pp_nxt;
    pp_idx_r <= pp_idx_nxt;
    result_r <= result_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = result_r;

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == STEP_LAST) |=> (done_r && !busy_r))
    else $error("mix unit did not finish after its last step");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("mix unit reports done while still busy");

  a_start_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && req.start) |=> (busy_r && step_r == STEP_PRE))
    else $error("mix unit ignored a start request");

endmodule

/* rtl/core/mul_xor_mix_string_hash64.sv */
// Multiply-xor string hash, 64 bits. One command word is taken at a time.
// A data byte on an open string runs one mix in the shared mix unit before the next word is
// taken, and one that opens a string runs the opening seed/basis mix first; a finish runs the
// same and then loads the output register once that register is free. Each mix goes through
// pre-rotate, four 32x32 partial products, last add, fold and handoff.
// Synchronous active-low reset closes any open string and sets rotate to 1, others to 0.
module mul_xor_mix_string_hash64 (
  input  logic                          clk,
  input  logic                          rst_n,
  mxh_cmd_if.sink                       in_word,
  mxh_hash_if.source                    out_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mxh_pkg::ADDR_W-1:0]    paddr,
  input  logic [mxh_pkg::WORD_W-1:0]    pwdata,
  output logic [mxh_pkg::WORD_W-1:0]    prdata,
  output logic                          pready
);

  localparam int W = mxh_pkg::WORD_W;

  // Sequencer states. OPEN runs the seed/basis mix that starts a string,
  // LAUNCH issues the mix for the accepted word, STEP waits for it and OUT
  // waits for the output register to be free.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_OPEN   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  mxh_pkg::mxh_cfg_t     cfg;
  mxh_pkg::mxh_mix_req_t mix_req;
  mxh_pkg::mxh_mix_rsp_t mix_rsp;

  logic [2:0]                 state_r, state_nxt;
  logic                       open_r, open_nxt;
  logic [W-1:0]               count_r, count_nxt;
  logic [W-1:0]               hash_r, hash_nxt;
  logic                       cmd_r, cmd_nxt;
  logic [mxh_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [W-1:0]               res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [W-1:0]               out_hash_r, out_hash_nxt;

  logic                       in_accept;
  logic                       out_free;
  logic [W-1:0]               step_a;

  mxh_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mxh_mix_unit u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (mix_req),
    .rsp   (mix_rsp)
  );

  // The block takes a word only when the sequencer is idle; a finished hash
  // may still sit in the output register meanwhile.
  assign in_word.ready = (state_r == S_IDLE);
  assign in_accept     = in_word.valid & in_word.ready;
  assign out_free      = ~out_valid_r | out_word.ready;

  // A data byte mixes in value plus one; a finish mixes in the byte count.
  assign step_a = (cmd_r == mxh_pkg::CMD_FINISH) ? count_r
                : ({{(W-mxh_pkg::BYTE_W){1'b0}}, byte_r} + {{(W-1){1'b0}}, 1'b1});

  // The opening mix starts in the accept cycle; the word's own mix starts
  // from LAUNCH once the running hash holds its value.
  always_comb begin
    mix_req.start = (in_accept && !open_r) || (state_r == S_LAUNCH);
    mix_req.a     = (state_r == S_LAUNCH) ? step_a : cfg.hash_seed;
    mix_req.b     = (state_r == S_LAUNCH) ? hash_r : cfg.mix_basis;
  end

  always_comb begin
    state_nxt     = state_r;
    open_nxt      = open_r;
    count_nxt     = count_r;
    hash_nxt      = hash_r;
    cmd_nxt       = cmd_r;
    byte_nxt      = byte_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_word.ready;
    out_hash_nxt  = out_hash_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt   = in_word.command;
          byte_nxt  = in_word.byte_value;
          state_nxt = open_r ? S_LAUNCH : S_OPEN;
        end
      end
      S_OPEN: begin
        if (mix_rsp.done) begin
          hash_nxt  = mix_rsp.result;
          count_nxt = '0;
          open_nxt  = 1'b1;
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (mix_rsp.done) begin
          if (cmd_r == mxh_pkg::CMD_BYTE) begin
            hash_nxt  = mix_rsp.result;
            count_nxt = count_r + {{(W-1){1'b0}}, 1'b1};
            state_nxt = S_IDLE;
          end else begin
            res_nxt   = mix_rsp.result;
            count_nxt = '0;
            open_nxt  = 1'b0;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The running hash is always written by the opening mix before use.
  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    cmd_r      <= cmd_nxt;
    byte_r     <= byte_nxt;
    res_r      <= res_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.hash_value = out_hash_r;

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    mix_req.start |-> !mix_rsp.busy)
    else $error("mix started while the unit was busy");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mix_rsp.done |-> (state_r == S_OPEN || state_r == S_STEP))
    else $error("mix result arrived with no mix outstanding");

  a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP && mix_rsp.done && cmd_r == mxh_pkg::CMD_FINISH)
      |=> (!open_r && count_r == '0 && state_r == S_OUT))
    else $error("finish did not close the string");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_word.ready) |=> (state_r == S_OUT))
    else $error("result overwrote a hash not yet taken");

endmodule
